// ===== hw/rtl/sst_pkg.sv =====
package sst_pkg;

  // Width of the wrapping seconds counter
  localparam int TIME_BITS = 16;

  localparam int POS_BITS  = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Position arithmetic headroom: two signed steps around a 13 bit position
  localparam int SUM_BITS  = POS_BITS + 2;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Spike level below which a locked target is released
  localparam logic signed [7:0] RELEASE_SPIKE = 8'sd5;

  // Run mode codes
  localparam logic [1:0] MODE_AUTO = 2'd1;
  localparam logic [1:0] MODE_CONT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MINTMP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PANIC  = 3'd7;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [POS_BITS-1:0]  pos_t;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_RIGHT = 2'd1,
    DRV_STOP  = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    SIDE_CENTRE = 2'd0,
    SIDE_UPPER  = 2'd1,
    SIDE_LOWER  = 2'd2
  } side_t;

  typedef struct packed {
    pos_t              home;
    pos_t              upper;
    pos_t              lower;
    logic [7:0]        step;
    logic signed [7:0] thresh;
    logic signed [7:0] min_temp;
    logic [15:0]       scan_window;
    logic [15:0]       panic_dur;
  } cfg_t;

  typedef struct packed {
    logic [15:0]       now_seconds;
    logic signed [7:0] temp_spike;
    logic signed [7:0] current_temp;
    logic [1:0]        run_mode;
    logic              rest_hold;
  } item_t;

  typedef struct packed {
    pos_t   pulse_width;
    logic   pulse_valid;
    drive_t drive_cmd;
    logic   clear_rest;
    logic   target_locked;
    logic   panic_active;
    side_t  spike_side;
  } result_t;

endpackage

// ===== hw/rtl/servo_sweep_thermal_scan.sv =====
// Thermal scanning servo controller. Each request is one loop tick (time in
// seconds, temperature spike, current temperature, run mode, rest flag) and
// yields exactly one result: the servo pulse written this tick, the drive
// command, the rest-clear pulse and the lock, panic and spike-side status.
// One request is taken every clock cycle unless out_stall holds the flow; a result passes
// through the input register, then the tick logic feeding the result register, and the
// scanner state updates on the edge that loads the result register, so consecutive ticks
// chain without bubbles. The user must write registers through the cfg_ port only while
// no request is in flight; the block itself does not enforce this. cfg_ready is always
// high.
module servo_sweep_thermal_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_now_seconds,
  input  logic signed [7:0]             in_temp_spike,
  input  logic signed [7:0]             in_current_temp,
  input  logic [1:0]                    in_run_mode,
  input  logic                          in_rest_hold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [12:0]                   out_pulse_width,
  output logic                          out_pulse_valid,
  output logic [1:0]                    out_drive_cmd,
  output logic                          out_clear_rest,
  output logic                          out_target_locked,
  output logic                          out_panic_active,
  output logic [1:0]                    out_spike_side,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_DAT_W-1:0] cfg_data
);

  sst_pkg::cfg_t    cfg;
  sst_pkg::item_t   in_item, st_item;
  sst_pkg::result_t tick_res, out_res;
  logic             st_valid, take;

  assign cfg_ready = 1'b1;

  sst_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pack the request fields
  assign in_item.now_seconds  = in_now_seconds;
  assign in_item.temp_spike   = in_temp_spike;
  assign in_item.current_temp = in_current_temp;
  assign in_item.run_mode     = in_run_mode;
  assign in_item.rest_hold    = in_rest_hold;

  sst_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (in_item),
    .dn_valid (st_valid),
    .dn_take  (take),
    .dn_item  (st_item)
  );

  sst_tick u_tick (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (st_valid && take),
    .item  (st_item),
    .cfg   (cfg),
    .res   (tick_res)
  );

  sst_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid),
    .up_take  (take),
    .up_res   (tick_res),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_res   (out_res)
  );

  // Unpack the result fields
  assign out_pulse_width   = out_res.pulse_width;
  assign out_pulse_valid   = out_res.pulse_valid;
  assign out_drive_cmd     = out_res.drive_cmd;
  assign out_clear_rest    = out_res.clear_rest;
  assign out_target_locked = out_res.target_locked;
  assign out_panic_active  = out_res.panic_active;
  assign out_spike_side    = out_res.spike_side;

endmodule

// ===== hw/rtl/sst_cfg.sv =====
module sst_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [sst_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sst_pkg::CFG_DAT_W-1:0] wr_data,
  output sst_pkg::cfg_t                 cfg
);

  sst_pkg::cfg_t cfg_r;

  // Write one register per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home        <= 13'd2785;
      cfg_r.upper       <= 13'd4800;
      cfg_r.lower       <= 13'd1100;
      cfg_r.step        <= 8'd2;
      cfg_r.thresh      <= 8'sd2;
      cfg_r.min_temp    <= 8'sd20;
      cfg_r.scan_window <= 16'd30;
      cfg_r.panic_dur   <= 16'd60;
    end else if (wr_en) begin
      case (wr_index)
        sst_pkg::REG_HOME:   cfg_r.home        <= wr_data[12:0];
        sst_pkg::REG_UPPER:  cfg_r.upper       <= wr_data[12:0];
        sst_pkg::REG_LOWER:  cfg_r.lower       <= wr_data[12:0];
        sst_pkg::REG_STEP:   cfg_r.step        <= wr_data[7:0];
        sst_pkg::REG_THRESH: cfg_r.thresh      <= $signed(wr_data[7:0]);
        sst_pkg::REG_MINTMP: cfg_r.min_temp    <= $signed(wr_data[7:0]);
        sst_pkg::REG_WIN:    cfg_r.scan_window <= wr_data;
        sst_pkg::REG_PANIC:  cfg_r.panic_dur   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/sst_in_stage.sv =====
module sst_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  sst_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_take,
  output sst_pkg::item_t dn_item
);

  logic           vld_r;
  sst_pkg::item_t item_r;

  // Stall only while a held request cannot move on
  assign up_stall = vld_r && !dn_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!up_stall) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = vld_r;
  assign dn_item  = item_r;

endmodule

// ===== hw/rtl/sst_tick.sv =====
module sst_tick (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sst_pkg::item_t   item,
  input  sst_pkg::cfg_t    cfg,
  output sst_pkg::result_t res
);

  // Scanner state
  sst_pkg::pos_t  pos_r, pos_nxt;
  logic           down_r, down_nxt;
  sst_pkg::pos_t  saved_r, saved_nxt;
  logic           tgt_r, tgt_nxt;
  logic           panic_r, panic_nxt;
  sst_pkg::time_t ws_r, ws_nxt;
  sst_pkg::side_t side_r, side_nxt;

  sst_pkg::time_t                       now_t;
  sst_pkg::time_t                       elapsed;
  logic                                 active;
  logic                                 hit;
  logic                                 chk_home, chk_up, chk_lo;
  logic                                 dir2;
  logic signed [sst_pkg::SUM_BITS-1:0]  step_s, p0, p1, p2;
  logic signed [sst_pkg::SUM_BITS-1:0]  upper_s, lower_s;
  sst_pkg::pos_t                        p_sat;

  assign now_t   = sst_pkg::time_t'(item.now_seconds);
  assign elapsed = now_t - ws_r;
  assign active  = (elapsed < sst_pkg::time_t'(cfg.scan_window) && !panic_r) || tgt_r ||
                   (item.run_mode == sst_pkg::MODE_CONT);

  // Sweep arithmetic: two bouncing steps
  assign step_s  = $signed({{(sst_pkg::SUM_BITS-8){1'b0}}, cfg.step});
  assign upper_s = $signed({2'b00, cfg.upper});
  assign lower_s = $signed({2'b00, cfg.lower});
  assign p0      = $signed({2'b00, pos_r});
  assign p1      = down_r ? (p0 - step_s) : (p0 + step_s);
  assign chk_home = (pos_r == cfg.home);
  assign chk_up   = (p1 > upper_s);
  assign chk_lo   = !chk_up && (p1 < lower_s);
  assign dir2     = chk_up ? 1'b1 : (chk_lo ? 1'b0 : down_r);
  assign p2       = dir2 ? (p1 - step_s) : (p1 + step_s);

  // Clamp final position to the servo range
  always_comb begin
    if (p2 < 0) begin
      p_sat = '0;
    end else if (p2 > $signed({2'b00, sst_pkg::POS_MAX})) begin
      p_sat = sst_pkg::POS_MAX;
    end else begin
      p_sat = p2[sst_pkg::POS_BITS-1:0];
    end
  end

  assign hit = (item.run_mode == sst_pkg::MODE_AUTO) && (item.temp_spike >= cfg.thresh);

  // Next state and result of one tick
  always_comb begin
    pos_nxt   = pos_r;
    down_nxt  = down_r;
    saved_nxt = saved_r;
    tgt_nxt   = tgt_r;
    panic_nxt = panic_r;
    ws_nxt    = ws_r;
    side_nxt  = side_r;
    res.pulse_width = '0;
    res.pulse_valid = 1'b0;
    res.drive_cmd   = sst_pkg::DRV_NONE;
    res.clear_rest  = 1'b0;
    if (active) begin
      res.pulse_valid = 1'b1;
      if (item.rest_hold) begin
        res.pulse_width = cfg.home;
      end else if (tgt_r) begin
        res.pulse_width = saved_r;
        if (item.temp_spike < sst_pkg::RELEASE_SPIKE) begin
          ws_nxt  = now_t;
          tgt_nxt = 1'b0;
        end
      end else begin
        // Last spike check in the tick decides the side
        if (hit && (chk_up || chk_lo || chk_home)) begin
          if (chk_up) begin
            side_nxt = sst_pkg::SIDE_UPPER;
          end else if (chk_lo) begin
            side_nxt = sst_pkg::SIDE_LOWER;
          end else begin
            side_nxt = sst_pkg::SIDE_CENTRE;
          end
          if (item.current_temp > cfg.min_temp) begin
            tgt_nxt = 1'b1;
          end
        end
        down_nxt        = dir2;
        pos_nxt         = p_sat;
        saved_nxt       = p_sat;
        res.pulse_width = p_sat;
      end
    end else if (!panic_r) begin
      panic_nxt     = 1'b1;
      ws_nxt        = now_t;
      res.drive_cmd = sst_pkg::DRV_RIGHT;
    end else if (elapsed >= sst_pkg::time_t'(cfg.panic_dur)) begin
      panic_nxt      = 1'b0;
      ws_nxt         = now_t;
      res.drive_cmd  = sst_pkg::DRV_STOP;
      res.clear_rest = 1'b1;
    end
    res.target_locked = tgt_nxt;
    res.panic_active  = panic_nxt;
    res.spike_side    = side_nxt;
  end

  // Advance state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 13'd2785;
      down_r  <= 1'b0;
      saved_r <= '0;
      tgt_r   <= 1'b0;
      panic_r <= 1'b0;
      ws_r    <= '0;
      side_r  <= sst_pkg::SIDE_CENTRE;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      down_r  <= down_nxt;
      saved_r <= saved_nxt;
      tgt_r   <= tgt_nxt;
      panic_r <= panic_nxt;
      ws_r    <= ws_nxt;
      side_r  <= side_nxt;
    end
  end

endmodule

// ===== hw/rtl/sst_out_stage.sv =====
module sst_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_take,
  input  sst_pkg::result_t up_res,
  output logic             dn_valid,
  input  logic             dn_stall,
  output sst_pkg::result_t dn_res
);

  logic             vld_r;
  sst_pkg::result_t res_r;

  // Take a new result when empty or when the held one leaves
  assign up_take = !vld_r || !dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_take) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_take) begin
      res_r <= up_res;
    end
  end

  assign dn_valid = vld_r;
  assign dn_res   = res_r;

endmodule

// ===== dv/servo_sweep_thermal_scan_tb.sv =====
module servo_sweep_thermal_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int NUM_REGS    = 1 << sst_pkg::CFG_IDX_W;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 50;

  typedef logic [sst_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [15:0]                   in_now_seconds = '0;
  logic signed [7:0]             in_temp_spike = '0;
  logic signed [7:0]             in_current_temp = '0;
  logic [1:0]                    in_run_mode = '0;
  logic                          in_rest_hold = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [12:0]                   out_pulse_width;
  logic                          out_pulse_valid;
  logic [1:0]                    out_drive_cmd;
  logic                          out_clear_rest;
  logic                          out_target_locked;
  logic                          out_panic_active;
  logic [1:0]                    out_spike_side;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  cfg_idx_t                      cfg_index = '0;
  logic [sst_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  servo_sweep_thermal_scan dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_now_seconds    (in_now_seconds),
    .in_temp_spike     (in_temp_spike),
    .in_current_temp   (in_current_temp),
    .in_run_mode       (in_run_mode),
    .in_rest_hold      (in_rest_hold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pulse_width   (out_pulse_width),
    .out_pulse_valid   (out_pulse_valid),
    .out_drive_cmd     (out_drive_cmd),
    .out_clear_rest    (out_clear_rest),
    .out_target_locked (out_target_locked),
    .out_panic_active  (out_panic_active),
    .out_spike_side    (out_spike_side),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scanner shadow: registers and state as the block should hold them
  sst_pkg::cfg_t  regs;
  int             sweep_pos;
  bit             sweep_down;
  sst_pkg::pos_t  saved_pos;
  bit             locked;
  bit             panicking;
  sst_pkg::time_t win_start;
  sst_pkg::side_t last_side;

  sst_pkg::result_t results_due[$];
  int               mismatch_count = 0;
  int               hold_left = 0;
  bit               calm = 1'b0;
  sst_pkg::time_t   clock_s = '0;
  int               cycles = 0;

  typedef struct {
    bit               is_cfg;
    sst_pkg::cfg_t    regs_to_load;
    sst_pkg::item_t   tick;
    bit               known;
    sst_pkg::result_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic sst_pkg::cfg_t reset_regs();
    sst_pkg::cfg_t c;
    c.home        = 13'd2785;
    c.upper       = 13'd4800;
    c.lower       = 13'd1100;
    c.step        = 8'd2;
    c.thresh      = 8'sd2;
    c.min_temp    = 8'sd20;
    c.scan_window = 16'd30;
    c.panic_dur   = 16'd60;
    return c;
  endfunction

  task automatic apply_reg(cfg_idx_t idx, logic [sst_pkg::CFG_DAT_W-1:0] data);
    case (idx)
      sst_pkg::REG_HOME:   regs.home        = data[12:0];
      sst_pkg::REG_UPPER:  regs.upper       = data[12:0];
      sst_pkg::REG_LOWER:  regs.lower       = data[12:0];
      sst_pkg::REG_STEP:   regs.step        = data[7:0];
      sst_pkg::REG_THRESH: regs.thresh      = data[7:0];
      sst_pkg::REG_MINTMP: regs.min_temp    = data[7:0];
      sst_pkg::REG_WIN:    regs.scan_window = data;
      sst_pkg::REG_PANIC:  regs.panic_dur   = data;
      default: ;
    endcase
  endtask

  // Latch the spike side, and the target if it is warm enough
  task automatic note_spike(sst_pkg::item_t it, sst_pkg::side_t side);
    if (it.run_mode == sst_pkg::MODE_AUTO &&
        $signed(it.temp_spike) >= $signed(regs.thresh)) begin
      last_side = side;
      if ($signed(it.current_temp) > $signed(regs.min_temp))
        locked = 1'b1;
    end
  endtask

  // Advance the shadow scanner by one tick and return the servo outcome
  task automatic step_scanner(input sst_pkg::item_t it, output sst_pkg::result_t r);
    sst_pkg::time_t elapsed;
    bit             active;
    int             p;
    int             d;
    elapsed = it.now_seconds - win_start;
    r = '0;
    active = (elapsed < regs.scan_window && !panicking) || locked ||
             it.run_mode == sst_pkg::MODE_CONT;
    if (active) begin
      r.pulse_valid = 1'b1;
      if (it.rest_hold) begin
        r.pulse_width = regs.home;
      end else if (locked) begin
        r.pulse_width = saved_pos;
        if ($signed(it.temp_spike) < sst_pkg::RELEASE_SPIKE) begin
          win_start = it.now_seconds;
          locked = 1'b0;
        end
      end else begin
        p = sweep_pos;
        if (p == int'(regs.home))
          note_spike(it, sst_pkg::SIDE_CENTRE);
        d = sweep_down ? -int'(regs.step) : int'(regs.step);
        p += d;
        if (p > int'(regs.upper)) begin
          sweep_down = 1'b1;
          note_spike(it, sst_pkg::SIDE_UPPER);
        end else if (p < int'(regs.lower)) begin
          sweep_down = 1'b0;
          note_spike(it, sst_pkg::SIDE_LOWER);
        end
        d = sweep_down ? -int'(regs.step) : int'(regs.step);
        p += d;
        if (p < 0) p = 0;
        if (p > int'(sst_pkg::POS_MAX)) p = int'(sst_pkg::POS_MAX);
        sweep_pos = p;
        saved_pos = sst_pkg::pos_t'(p);
        r.pulse_width = sst_pkg::pos_t'(p);
      end
    end else if (!panicking) begin
      panicking = 1'b1;
      win_start = it.now_seconds;
      r.drive_cmd = sst_pkg::DRV_RIGHT;
    end else if (elapsed >= regs.panic_dur) begin
      panicking = 1'b0;
      win_start = it.now_seconds;
      r.drive_cmd = sst_pkg::DRV_STOP;
      r.clear_rest = 1'b1;
    end
    r.target_locked = locked;
    r.panic_active = panicking;
    r.spike_side = last_side;
  endtask

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic check_result();
    sst_pkg::result_t want;
    if (results_due.size() == 0) begin
      log_mismatch("result with no request outstanding");
      return;
    end
    want = results_due.pop_front();
    compare_field("pulse_width", 16'(out_pulse_width), 16'(want.pulse_width));
    compare_field("pulse_valid", 16'(out_pulse_valid), 16'(want.pulse_valid));
    compare_field("drive_cmd", 16'(out_drive_cmd), 16'(want.drive_cmd));
    compare_field("clear_rest", 16'(out_clear_rest), 16'(want.clear_rest));
    compare_field("target_locked", 16'(out_target_locked), 16'(want.target_locked));
    compare_field("panic_active", 16'(out_panic_active), 16'(want.panic_active));
    compare_field("spike_side", 16'(out_spike_side), 16'(want.spike_side));
  endtask

  function automatic int draw_wait();
    if (calm)
      return 0;
    return int'($urandom_range(11, 0));
  endfunction

  // Result side: check each accepted result, then stall for a drawn while
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      int n;
      check_result();
      n = draw_wait();
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one request after a drawn gap; hold it until taken
  task automatic send_tick(sst_pkg::item_t it, bit known, sst_pkg::result_t want);
    int               gap;
    sst_pkg::result_t r;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_now_seconds  <= it.now_seconds;
    in_temp_spike   <= it.temp_spike;
    in_current_temp <= it.current_temp;
    in_run_mode     <= it.run_mode;
    in_rest_hold    <= it.rest_hold;
    do @(posedge clk); while (in_stall);
    step_scanner(it, r);
    results_due.push_back(known ? want : r);
  endtask

  // Stop sending and wait until every request has its result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // Write the whole register set; unused high data bits carry junk
  task automatic load_regs(sst_pkg::cfg_t c);
    logic [sst_pkg::CFG_DAT_W-1:0] vals [NUM_REGS];
    vals[sst_pkg::REG_HOME]   = {3'($urandom), c.home};
    vals[sst_pkg::REG_UPPER]  = {3'($urandom), c.upper};
    vals[sst_pkg::REG_LOWER]  = {3'($urandom), c.lower};
    vals[sst_pkg::REG_STEP]   = {8'($urandom), c.step};
    vals[sst_pkg::REG_THRESH] = {8'($urandom), c.thresh};
    vals[sst_pkg::REG_MINTMP] = {8'($urandom), c.min_temp};
    vals[sst_pkg::REG_WIN]    = c.scan_window;
    vals[sst_pkg::REG_PANIC]  = c.panic_dur;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t tick_row(sst_pkg::time_t now, logic signed [7:0] spk,
                                         logic signed [7:0] tmp, logic [1:0] mode,
                                         logic rest);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.regs_to_load = '0;
    r.tick = '{now_seconds: now, temp_spike: spk, current_temp: tmp,
               run_mode: mode, rest_hold: rest};
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t known_row(plan_row_t r, sst_pkg::pos_t pw, logic pv,
                                          sst_pkg::drive_t dc, logic clr, logic tl,
                                          logic pa, sst_pkg::side_t sd);
    r.known = 1'b1;
    r.want = '{pulse_width: pw, pulse_valid: pv, drive_cmd: dc, clear_rest: clr,
               target_locked: tl, panic_active: pa, spike_side: sd};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(sst_pkg::cfg_t c);
    plan_row_t r;
    r = tick_row('0, '0, '0, MODE_OTHER, 1'b0);
    r.is_cfg = 1'b1;
    r.regs_to_load = c;
    return r;
  endfunction

  function automatic int pick(int lo, int hi, int a, int b);
    case ($urandom_range(4, 0))
      0: return lo;
      1: return hi;
      default: return a + int'($urandom_range(b - a, 0));
    endcase
  endfunction

  // First two phases take every register to its floor, then its ceiling
  function automatic sst_pkg::cfg_t draw_regs(int ph);
    sst_pkg::cfg_t c;
    if (ph == 0) begin
      c = '{home: '0, upper: '0, lower: '0, step: 8'd1, thresh: 8'sh80,
            min_temp: 8'sh80, scan_window: '0, panic_dur: '0};
    end else if (ph == 1) begin
      c = '{home: '1, upper: '1, lower: '1, step: 8'd255, thresh: 8'sh7f,
            min_temp: 8'sh7f, scan_window: '1, panic_dur: '1};
    end else begin
      c.home        = 13'(pick(0, 8191, 1000, 5000));
      c.upper       = 13'(pick(0, 8191, 2000, 8191));
      c.lower       = 13'(pick(0, 8191, 0, 2000));
      c.step        = 8'(pick(1, 255, 1, 40));
      c.thresh      = 8'(pick(-128, 127, -10, 30));
      c.min_temp    = 8'(pick(-128, 127, -10, 40));
      c.scan_window = 16'(pick(0, 65535, 0, 60));
      c.panic_dur   = 16'(pick(0, 65535, 0, 60));
    end
    return c;
  endfunction

  // Mostly creeping time with the odd jump, biased towards automatic mode
  task automatic draw_tick(output sst_pkg::item_t it);
    int m;
    if ($urandom_range(24, 0) == 0)
      clock_s = sst_pkg::time_t'($urandom);
    else
      clock_s += sst_pkg::time_t'($urandom_range(12, 0));
    m = int'($urandom_range(9, 0));
    it.now_seconds  = clock_s;
    it.temp_spike   = 8'($urandom);
    it.current_temp = 8'($urandom);
    it.run_mode     = (m < 5) ? sst_pkg::MODE_AUTO : (m < 7) ? sst_pkg::MODE_CONT :
                      (m < 8) ? MODE_OTHER : MODE_SPARE;
    it.rest_hold    = ($urandom_range(9, 0) == 0);
  endtask

  initial begin
    sst_pkg::cfg_t  c;
    sst_pkg::item_t it;

    regs       = reset_regs();
    sweep_pos  = 2785;
    sweep_down = 1'b0;
    saved_pos  = '0;
    locked     = 1'b0;
    panicking  = 1'b0;
    win_start  = '0;
    last_side  = sst_pkg::SIDE_CENTRE;

    // Rest at home, lock at centre, release, spare mode sweeps
    plan.push_back(known_row(tick_row(16'd0, 8'sd0, 8'sd0, MODE_OTHER, 1'b1),
                             13'd2785, 1'b1, sst_pkg::DRV_NONE, 1'b0, 1'b0, 1'b0,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(known_row(tick_row(16'd1, 8'sh7f, 8'sh7f, sst_pkg::MODE_AUTO, 1'b0),
                             13'd2789, 1'b1, sst_pkg::DRV_NONE, 1'b0, 1'b1, 1'b0,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(known_row(tick_row(16'd2, 8'sh80, 8'sh80, MODE_OTHER, 1'b0),
                             13'd2789, 1'b1, sst_pkg::DRV_NONE, 1'b0, 1'b0, 1'b0,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(tick_row(16'd3, 8'sh7f, 8'sh7f, MODE_SPARE, 1'b0));
    // Window runs out: panic turn, idle panic, continuous sweep in panic, stop
    plan.push_back(known_row(tick_row(16'd32, 8'sd0, 8'sd0, MODE_OTHER, 1'b0),
                             13'd0, 1'b0, sst_pkg::DRV_RIGHT, 1'b0, 1'b0, 1'b1,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(known_row(tick_row(16'd33, 8'sd0, 8'sd0, MODE_OTHER, 1'b0),
                             13'd0, 1'b0, sst_pkg::DRV_NONE, 1'b0, 1'b0, 1'b1,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(tick_row(16'd40, 8'sd5, 8'sh7f, sst_pkg::MODE_CONT, 1'b0));
    plan.push_back(known_row(tick_row(16'd92, 8'sd0, 8'sd0, MODE_OTHER, 1'b0),
                             13'd0, 1'b0, sst_pkg::DRV_STOP, 1'b1, 1'b0, 1'b0,
                             sst_pkg::SIDE_CENTRE));
    // Time wraps through zero across a panic
    plan.push_back(known_row(tick_row(16'hffff, -8'sd1, 8'sd0, MODE_OTHER, 1'b1),
                             13'd0, 1'b0, sst_pkg::DRV_RIGHT, 1'b0, 1'b0, 1'b1,
                             sst_pkg::SIDE_CENTRE));
    plan.push_back(tick_row(16'd0, 8'sd0, 8'sd0, MODE_OTHER, 1'b0));
    plan.push_back(tick_row(16'd59, 8'sd0, 8'sd0, MODE_OTHER, 1'b0));
    // Narrow limits: bounce at both ends, lock on the lower one, hold, release
    c = reset_regs();
    c.upper = 13'd3000;
    c.lower = 13'd2700;
    c.step = 8'd255;
    c.scan_window = 16'hffff;
    plan.push_back(cfg_row(c));
    plan.push_back(tick_row(16'd60, 8'sd10, -8'sd5, sst_pkg::MODE_AUTO, 1'b0));
    plan.push_back(tick_row(16'd61, 8'sd2, 8'sd21, sst_pkg::MODE_AUTO, 1'b0));
    plan.push_back(tick_row(16'd62, 8'sd5, 8'sd0, sst_pkg::MODE_AUTO, 1'b0));
    plan.push_back(tick_row(16'd63, 8'sd4, 8'sd0, MODE_OTHER, 1'b0));
    // Open the top limit and climb until the position clips at full scale
    c.upper = 13'h1fff;
    plan.push_back(cfg_row(c));
    for (int k = 0; k < 11; k++)
      plan.push_back(tick_row(sst_pkg::time_t'(64 + k), 8'sd0, 8'sd0,
                              sst_pkg::MODE_CONT, 1'b0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        load_regs(plan[i].regs_to_load);
      end else begin
        send_tick(plan[i].tick, plan[i].known, plan[i].want);
      end
    end

    // Random phases, each behind a full drain and a fresh register set
    clock_s = 16'd100;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      load_regs(draw_regs(ph));
      calm = (ph == 3);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        draw_tick(it);
        send_tick(it, 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
